// File: hw/rtl/dclru_pkg.sv
// Shared types, codes and default geometry for the Dragon coherent LRU cache unit.
package dclru_pkg;

    // Default geometry
    localparam int unsigned DEF_NUM_SETS       = 64;
    localparam int unsigned DEF_NUM_WAYS       = 2;
    localparam int unsigned DEF_WORDS_PER_LINE = 8;

    localparam int unsigned WORD_BYTES = 4;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 112;

    // Request kinds
    localparam logic [2:0] MODE_LOAD      = 3'd0;
    localparam logic [2:0] MODE_STORE     = 3'd1;
    localparam logic [2:0] MODE_SNP_READ  = 3'd2;
    localparam logic [2:0] MODE_SNP_UPD   = 3'd3;
    localparam logic [2:0] MODE_READ_DONE = 3'd4;
    localparam logic [2:0] MODE_UPD_DONE  = 3'd5;

    // Bus commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_UPD   = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    // Coherence states
    localparam logic [1:0] ST_E  = 2'd0;
    localparam logic [1:0] ST_SC = 2'd1;
    localparam logic [1:0] ST_SM = 2'd2;
    localparam logic [1:0] ST_M  = 2'd3;
    localparam logic [2:0] LS_ABSENT = 3'd4;

    // Snoop supply codes
    localparam logic [1:0] SUP_NONE  = 2'd0;
    localparam logic [1:0] SUP_CLEAN = 2'd1;
    localparam logic [1:0] SUP_DIRTY = 2'd2;

    // One result, lowest field last
    typedef struct packed {
        logic [2:0]  line_state;
        logic        access_shared;
        logic [1:0]  snoop_supply;
        logic        snoop_shared;
        logic [31:0] bus_word;
        logic [31:0] bus_address;
        logic [1:0]  bus_cmd;
        logic [31:0] read_word;
        logic        hit;
    } t_result;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_res_entry;

endpackage

// File: hw/rtl/dclru_tag_mem.sv
// Per-set tag, state, age and word-mask memory plus presence flags.
module dclru_tag_mem
    import dclru_pkg::*;
#(
    parameter int unsigned SETS = DEF_NUM_SETS,
    parameter int unsigned WAYS = DEF_NUM_WAYS,
    parameter int unsigned ROWW = 8,
    parameter int unsigned SIDX = 6
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [SIDX-1:0] i_rd_set,
    input  logic            i_wr_en,
    input  logic [SIDX-1:0] i_wr_set,
    input  logic [ROWW-1:0] i_wr_row,
    input  logic [WAYS-1:0] i_wr_pres,
    output logic [ROWW-1:0] o_rd_row,
    output logic [WAYS-1:0] o_rd_pres
);

    logic [ROWW-1:0] r_mem [SETS];
    logic [WAYS-1:0] r_pres [SETS];

    // Write and read the row array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            o_rd_row <= r_mem[i_rd_set];
        end
    end

    // Presence flags clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_pres[s] <= '0;
            end
            o_rd_pres <= '0;
        end else begin
            if (i_wr_en) begin
                r_pres[i_wr_set] <= i_wr_pres;
            end
            if (i_rd_en) begin
                o_rd_pres <= r_pres[i_rd_set];
            end
        end
    end

endmodule

// File: hw/rtl/dclru_word_mem.sv
// Line word memory: one row holds the same word of every way in a set.
module dclru_word_mem #(
    parameter int unsigned DEPTH = 512,
    parameter int unsigned WIDX  = 9,
    parameter int unsigned ROWW  = 64
) (
    input  logic            i_clk,
    input  logic            i_rd_en,
    input  logic [WIDX-1:0] i_rd_idx,
    input  logic            i_wr_en,
    input  logic [WIDX-1:0] i_wr_idx,
    input  logic [ROWW-1:0] i_wr_row,
    output logic [ROWW-1:0] o_rd_row
);

    logic [ROWW-1:0] r_mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_row;
        end
        if (i_rd_en) begin
            o_rd_row <= r_mem[i_rd_idx];
        end
    end

endmodule

// File: hw/rtl/dclru_res_fifo.sv
// Four-entry result queue taking up to two results per cycle.
module dclru_res_fifo
    import dclru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push0,
    input  t_res_entry i_ent0,
    input  logic       i_push1,
    input  t_res_entry i_ent1,
    output logic       o_room2,
    output logic       o_valid,
    output t_res_entry o_ent,
    input  logic       i_pop
);

    t_res_entry r_q [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       pop;
    logic [2:0] n_push;

    assign o_valid = (r_cnt != 3'd0);
    assign o_ent   = r_q[r_rp];
    assign pop     = o_valid && i_pop;
    assign o_room2 = (r_cnt <= 3'd2);
    assign n_push  = {2'b00, i_push0} + {2'b00, i_push1};

    // Store payload
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_q[r_wp] <= i_ent0;
        end
        if (i_push1) begin
            r_q[r_wp + 2'd1] <= i_ent1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_push[1:0];
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= r_cnt + n_push - {2'b00, pop};
        end
    end

endmodule

// File: hw/rtl/dragon_coherent_lru_cache_unit.sv
// Top level of the Dragon coherent LRU cache unit.
// Each request is accepted in the idle state, which reads the set's tag row and word row from
// synchronous memories; the lookup state compares tags, updates state, LRU ages and the word,
// and queues one or two results (a dirty-victim flush comes first, then the bus read). The
// synchronous tag memory read is why the lookup has its own state. A four-entry result queue
// lets the next request in while earlier results wait. Line words of a fresh allocation read as
// zero through a per-line written mask, so no fill pass is needed; presence flags clear at reset.
// Geometry parameters are expected to be powers of two.
module dragon_coherent_lru_cache_unit
    import dclru_pkg::*;
#(
    parameter int unsigned NUM_SETS       = DEF_NUM_SETS,
    parameter int unsigned NUM_WAYS       = DEF_NUM_WAYS,
    parameter int unsigned WORDS_PER_LINE = DEF_WORDS_PER_LINE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // mode[2:0], address[34:3], data_word[66:35], shared_seen[67], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // hit, read_word, bus_cmd, bus_address, bus_word, snoop_shared, snoop_supply,
    // access_shared, line_state, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tlast
);

    localparam int unsigned OFFB = $clog2(WORDS_PER_LINE) + 2;
    localparam int unsigned SETB = $clog2(NUM_SETS);
    localparam int unsigned TAGB = 32 - OFFB - SETB;
    localparam int unsigned SIDX = (SETB > 0) ? SETB : 1;
    localparam int unsigned OFW  = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int unsigned AGW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned WYW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int unsigned WAYW = TAGB + 2 + AGW + WORDS_PER_LINE;
    localparam int unsigned ROWW = WAYW * NUM_WAYS;
    localparam int unsigned WDEP = NUM_SETS * WORDS_PER_LINE;
    localparam int unsigned WIDX = (WDEP > 1) ? $clog2(WDEP) : 1;
    localparam int unsigned WROW = WORD_W * NUM_WAYS;

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state      r_state;
    logic [2:0]  r_mode;
    logic [31:0] r_addr;
    logic [31:0] r_data;
    logic        r_shared;
    logic        r_pend;
    logic [31:0] r_pword;
    logic        n_pend;
    logic [31:0] n_pword;

    logic in_acc;
    logic room2;
    logic [31:0] in_addr;

    logic [ROWW-1:0]     tag_row;
    logic [NUM_WAYS-1:0] pres_row;
    logic [WROW-1:0]     word_row;

    logic [SIDX-1:0] in_set, cur_set;
    logic [WIDX-1:0] in_widx, cur_widx;
    logic [OFW-1:0]  cur_off;
    logic [TAGB-1:0] cur_tag;

    // Per-way fields of the current row, before and after
    logic [TAGB-1:0]           w_tag  [NUM_WAYS];
    logic [1:0]                w_coh  [NUM_WAYS];
    logic [AGW-1:0]            w_age  [NUM_WAYS];
    logic [WORDS_PER_LINE-1:0] w_mask [NUM_WAYS];
    logic [TAGB-1:0]           n_tag  [NUM_WAYS];
    logic [1:0]                n_coh  [NUM_WAYS];
    logic [AGW-1:0]            n_age  [NUM_WAYS];
    logic [WORDS_PER_LINE-1:0] n_mask [NUM_WAYS];
    logic [NUM_WAYS-1:0]       n_pres;
    logic [ROWW-1:0]           n_row;
    logic [WROW-1:0]           n_wrow;
    logic                      word_we;

    logic        present, found, freefound, dirty, do_promote, emit;
    logic [WYW-1:0] hw, fw, vw, way;
    logic [AGW:0]   old_rank, best;
    logic [31:0]    sel_word;
    logic [31:0]    flush_a;
    t_result     res;
    t_res_entry  ent0, ent1;
    logic        push0, push1;
    t_res_entry  head;

    assign in_addr  = i_s_axis_tdata[34:3];
    assign in_set   = SIDX'((in_addr >> OFFB) % NUM_SETS);
    assign in_widx  = WIDX'((in_addr >> 2) % WDEP);
    assign cur_set  = SIDX'((r_addr >> OFFB) % NUM_SETS);
    assign cur_widx = WIDX'((r_addr >> 2) % WDEP);
    assign cur_off  = OFW'((r_addr >> 2) % WORDS_PER_LINE);
    assign cur_tag  = TAGB'(r_addr >> (OFFB + SETB));

    assign o_s_axis_tready = (r_state == S_IDLE) && room2;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    dclru_tag_mem #(
        .SETS (NUM_SETS),
        .WAYS (NUM_WAYS),
        .ROWW (ROWW),
        .SIDX (SIDX)
    ) u_tag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_set  (in_set),
        .i_wr_en   (r_state == S_LOOK),
        .i_wr_set  (cur_set),
        .i_wr_row  (n_row),
        .i_wr_pres (n_pres),
        .o_rd_row  (tag_row),
        .o_rd_pres (pres_row)
    );

    dclru_word_mem #(
        .DEPTH (WDEP),
        .WIDX  (WIDX),
        .ROWW  (WROW)
    ) u_word (
        .i_clk    (i_clk),
        .i_rd_en  (in_acc),
        .i_rd_idx (in_widx),
        .i_wr_en  (word_we),
        .i_wr_idx (cur_widx),
        .i_wr_row (n_wrow),
        .o_rd_row (word_row)
    );

    // Unpack the row and find the hit way
    always_comb begin
        found = 1'b0;
        hw    = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_tag[w]  = tag_row[w*WAYW +: TAGB];
            w_coh[w]  = tag_row[w*WAYW + TAGB +: 2];
            w_age[w]  = tag_row[w*WAYW + TAGB + 2 +: AGW];
            w_mask[w] = tag_row[w*WAYW + TAGB + 2 + AGW +: WORDS_PER_LINE];
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (pres_row[w] && (w_tag[w] == cur_tag)) begin
                found = 1'b1;
                hw    = WYW'(w);
            end
        end
    end

    // Pick a free way, else the oldest way
    always_comb begin
        freefound = 1'b0;
        fw        = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (!pres_row[w]) begin
                freefound = 1'b1;
                fw        = WYW'(w);
            end
        end
        vw   = '0;
        best = {1'b0, w_age[0]};
        for (int w = 1; w < NUM_WAYS; w++) begin
            if ({1'b0, w_age[w]} > best) begin
                best = {1'b0, w_age[w]};
                vw   = WYW'(w);
            end
        end
    end

    // Resolve the request against the set
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            n_tag[w]  = w_tag[w];
            n_coh[w]  = w_coh[w];
            n_age[w]  = w_age[w];
            n_mask[w] = w_mask[w];
        end
        n_pres     = pres_row;
        n_wrow     = word_row;
        word_we    = 1'b0;
        n_pend     = r_pend;
        n_pword    = r_pword;
        present    = found;
        way        = hw;
        dirty      = 1'b0;
        flush_a    = '0;
        do_promote = 1'b0;
        old_rank   = {1'b0, w_age[hw]};
        emit       = (r_mode <= MODE_UPD_DONE);
        sel_word   = word_row[hw*WORD_W +: WORD_W];
        res        = '0;

        unique case (r_mode)
            MODE_LOAD, MODE_STORE: begin
                if (found) begin
                    res.access_shared = (w_coh[hw] == ST_SC) || (w_coh[hw] == ST_SM);
                    do_promote = 1'b1;
                    if (r_mode == MODE_LOAD) begin
                        res.hit       = 1'b1;
                        res.read_word = w_mask[hw][cur_off] ? sel_word : '0;
                    end else begin
                        n_wrow[hw*WORD_W +: WORD_W] = r_data;
                        n_mask[hw][cur_off] = 1'b1;
                        word_we = 1'b1;
                        if ((w_coh[hw] == ST_E) || (w_coh[hw] == ST_M)) begin
                            res.hit   = 1'b1;
                            n_coh[hw] = ST_M;
                        end else begin
                            res.bus_cmd     = CMD_UPD;
                            res.bus_address = {r_addr[31:2], 2'b00};
                            res.bus_word    = r_data;
                        end
                    end
                end else begin
                    // Allocate, flushing a dirty victim
                    way = freefound ? fw : vw;
                    if (!freefound && ((w_coh[vw] == ST_SM) || (w_coh[vw] == ST_M))) begin
                        dirty   = 1'b1;
                        flush_a = (32'(w_tag[vw]) << (SETB + OFFB)) |
                                  (32'(cur_set) << OFFB);
                    end
                    present       = 1'b1;
                    n_pres[way]   = 1'b1;
                    n_tag[way]    = cur_tag;
                    n_coh[way]    = ST_E;
                    n_mask[way]   = '0;
                    do_promote    = 1'b1;
                    old_rank      = (AGW+1)'(NUM_WAYS);
                    res.bus_cmd     = CMD_READ;
                    res.bus_address = {r_addr[31:OFFB], OFFB'(0)};
                    if (r_mode == MODE_STORE) begin
                        n_wrow[way*WORD_W +: WORD_W] = r_data;
                        n_mask[way][cur_off] = 1'b1;
                        word_we = 1'b1;
                        n_pend  = 1'b1;
                        n_pword = r_data;
                    end
                end
            end
            MODE_SNP_READ: begin
                if (found) begin
                    res.snoop_shared = 1'b1;
                    unique case (w_coh[hw])
                        ST_E: begin
                            res.snoop_supply = SUP_CLEAN;
                            n_coh[hw] = ST_SC;
                        end
                        ST_SM: res.snoop_supply = SUP_DIRTY;
                        ST_M: begin
                            res.snoop_supply = SUP_DIRTY;
                            n_coh[hw] = ST_SM;
                        end
                        default: res.snoop_supply = SUP_NONE;
                    endcase
                end
            end
            MODE_SNP_UPD: begin
                if (found && (w_coh[hw] != ST_M)) begin
                    res.snoop_shared = 1'b1;
                    n_wrow[hw*WORD_W +: WORD_W] = r_data;
                    n_mask[hw][cur_off] = 1'b1;
                    word_we   = 1'b1;
                    n_coh[hw] = ST_SC;
                end
            end
            MODE_READ_DONE: begin
                if (found) begin
                    n_coh[hw] = r_shared ? ST_SC : ST_E;
                end
                if (r_pend) begin
                    n_pend = 1'b0;
                    if (found && !r_shared) begin
                        n_coh[hw] = ST_M;
                    end else begin
                        res.bus_cmd     = CMD_UPD;
                        res.bus_address = {r_addr[31:2], 2'b00};
                        res.bus_word    = r_pword;
                    end
                end
            end
            MODE_UPD_DONE: begin
                if (found) begin
                    n_coh[hw] = r_shared ? ST_SM : ST_M;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // Move the touched way to most recent
        if (do_promote) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if ((WYW'(w) != way) && n_pres[w] && ({1'b0, w_age[w]} < old_rank)) begin
                    n_age[w] = w_age[w] + AGW'(1);
                end
            end
            n_age[way] = '0;
        end

        res.line_state = present ? {1'b0, n_coh[way]} : LS_ABSENT;

        for (int w = 0; w < NUM_WAYS; w++) begin
            n_row[w*WAYW +: WAYW] = {n_mask[w], n_age[w], n_coh[w], n_tag[w]};
        end
        if (r_state != S_LOOK) begin
            word_we = 1'b0;
        end
    end

    // Build queue entries: flush first when present
    always_comb begin
        ent0.res             = res;
        ent0.last            = !dirty;
        ent1.res             = res;
        ent1.last            = 1'b1;
        if (dirty) begin
            ent0.res.bus_cmd     = CMD_FLUSH;
            ent0.res.bus_address = flush_a;
            ent0.res.bus_word    = '0;
        end
        push0 = (r_state == S_LOOK) && emit;
        push1 = (r_state == S_LOOK) && emit && dirty;
    end

    dclru_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_ent0  (ent0),
        .i_push1 (push1),
        .i_ent1  (ent1),
        .o_room2 (room2),
        .o_valid (o_m_axis_tvalid),
        .o_ent   (head),
        .i_pop   (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {6'b0, head.res};
    assign o_m_axis_tlast = head.last;

    // Hold the request and advance the sequencer
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= i_s_axis_tdata[2:0];
            r_addr   <= in_addr;
            r_data   <= i_s_axis_tdata[66:35];
            r_shared <= i_s_axis_tdata[67];
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_pword <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_IDLE;
                    r_pend  <= n_pend;
                    r_pword <= n_pword;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
